/* rtl/ddsf_pkg.sv */
// Package for the door drive speed controller: travel state codes,
// configuration indexes, field widths and the result record.
// No dependencies.
package ddsf_pkg;

  localparam int SPEED_W  = 15;  // magnitude of a configured speed
  localparam int DRIVE_W  = 16;  // signed drive command
  localparam int SW_N     = 4;   // number of position switches
  localparam int STATE_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int HOME_W   = 13;  // max_speed / 5 fits in 13 bits
  localparam int CRUISE_W = 14;  // max_speed / 2 fits in 14 bits

  // floor(x / 5) == (x * 52429) >> 18 for every x below 2**16.
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  localparam logic [HOME_W-1:0]   HOME_RST   = 13'd200;
  localparam logic [CRUISE_W-1:0] CRUISE_RST = 14'd500;
  localparam logic [SPEED_W-1:0]  CREEP_RST  = 15'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 2'd1;

  // Switch positions from the open end to the closed end.
  localparam int SW_OPEN_END  = 0;
  localparam int SW_ACC_EDGE  = 1;
  localparam int SW_DEC_EDGE  = 2;
  localparam int SW_CLOSE_END = 3;

  typedef enum logic [STATE_W-1:0] {
    ST_INIT        = 4'd0,
    ST_HOMING      = 4'd1,
    ST_OPEN        = 4'd2,
    ST_SPEEDUP_CLS = 4'd3,
    ST_POS         = 4'd4,
    ST_SLOWDN_CLS  = 4'd5,
    ST_SHUT        = 4'd6,
    ST_SPEEDUP_OPN = 4'd7,
    ST_NEG         = 4'd8,
    ST_SLOWDN_OPN  = 4'd9
  } travel_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_speed;
    logic [STATE_W-1:0]        state_code;
    logic [SW_N-1:0]           switch_changed;
  } result_t;

endpackage

/* rtl/ddsf_in_if.sv */
// Request channel into the door drive controller: direction and switch levels.
// No dependencies.
interface ddsf_in_if;
  logic       valid;
  logic       ready;
  logic       dir_close;
  logic [3:0] switch_levels;

  modport source (output valid, output dir_close, output switch_levels, input ready);
  modport sink   (input valid, input dir_close, input switch_levels, output ready);
endinterface

/* rtl/ddsf_out_if.sv */
// Result channel out of the door drive controller: speed, state and switch flags.
// No dependencies.
interface ddsf_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] drive_speed;
  logic [3:0]        state_code;
  logic [3:0]        switch_changed;

  modport source (output valid, output drive_speed, output state_code,
                  output switch_changed, input ready);
  modport sink   (input valid, input drive_speed, input state_code,
                  input switch_changed, output ready);
endinterface

/* rtl/ddsf_cfg_if.sv */
// Register write channel of the door drive controller.
// No dependencies.
interface ddsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [14:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

/* rtl/door_drive_speed_fsm_top.sv */
// Top level of the door drive speed controller: travel state machine,
// speed registers and a two-entry result buffer.
// Depends on ddsf_pkg, ddsf_in_if, ddsf_out_if and ddsf_cfg_if.
//
// Usage:
// Each request on in_ch is one control tick carrying the commanded direction
// and the four position switch levels. Every request yields exactly one result
// on out_ch: the signed speed command held after the tick, the travel state
// code and the per-switch change flags.
// The result of an accepted request is registered in the output register, or in
// the skid register while the output register is held. One request is taken per
// cycle while the skid register is empty; the state machine update is a single
// level of compare and select between the state registers and the result register.
// The result side has an output register plus a skid register, so a request is
// still taken while one result waits for the receiver. If the receiver stalls
// long enough for both entries to fill, in_ch.ready drops until out_ch drains.
// Register writes on cfg_ch are always taken (ready is tied high). The home and
// cruise speeds are derived from max_speed at write time, so the tick path only
// selects among stored values. Writes take effect at the next speed change.
// Reset (rst_n low, synchronous) returns the state machine to init, the held
// speed and previous switch levels to zero, the speeds to their defaults, and
// empties the result buffer.
module door_drive_speed_fsm_top (
  input logic       clk,
  input logic       rst_n,
  ddsf_in_if.sink   in_ch,
  ddsf_out_if.source out_ch,
  ddsf_cfg_if.sink  cfg_ch
);
  import ddsf_pkg::*;

  // Configured speeds, kept in the form the state machine uses them.
  logic [HOME_W-1:0]   home_r;
  logic [CRUISE_W-1:0] cruise_r;
  logic [SPEED_W-1:0]  creep_r;
  logic [SPEED_W+15:0] div5_prod;

  // Tick state.
  travel_t                   state_r, state_nxt;
  logic signed [DRIVE_W-1:0] speed_r, speed_nxt;
  logic [SW_N-1:0]           prev_r;

  // Result buffer: output register and skid register.
  result_t out_r, skid_r, res_nxt;
  logic    out_v_r, skid_v_r;

  logic            accept;
  logic            out_free;
  logic [SW_N-1:0] ev;
  logic            to_close;

  logic signed [DRIVE_W-1:0] home_p, home_n, cruise_p, cruise_n, creep_p, creep_n;

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;
  assign div5_prod    = (SPEED_W+16)'(cfg_ch.data) * (SPEED_W+16)'(DIV5_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r   <= HOME_RST;
      cruise_r <= CRUISE_RST;
      creep_r  <= CREEP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        CFG_MAX_SPEED: begin
          home_r   <= div5_prod[DIV5_SHIFT +: HOME_W];
          cruise_r <= cfg_ch.data[SPEED_W-1:1];
        end
        CFG_MIN_SPEED: begin
          creep_r <= cfg_ch.data;
        end
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------------ tick logic
  assign accept   = in_ch.valid && in_ch.ready;
  assign ev       = in_ch.switch_levels ^ prev_r;
  assign to_close = in_ch.dir_close;

  assign home_p   = DRIVE_W'(home_r);
  assign home_n   = -home_p;
  assign cruise_p = DRIVE_W'(cruise_r);
  assign cruise_n = -cruise_p;
  assign creep_p  = DRIVE_W'(creep_r);
  assign creep_n  = -creep_p;

  // Next travel state. A switch event takes priority over a reversal.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:    state_nxt = ST_HOMING;
      ST_HOMING: begin
        if (!to_close && ev[SW_OPEN_END])      state_nxt = ST_OPEN;
        else if (to_close && ev[SW_CLOSE_END]) state_nxt = ST_SHUT;
      end
      ST_OPEN:    if (to_close) state_nxt = ST_SPEEDUP_CLS;
      ST_SPEEDUP_CLS: begin
        if (ev[SW_ACC_EDGE])   state_nxt = ST_POS;
        else if (!to_close)    state_nxt = ST_SLOWDN_OPN;
      end
      ST_POS: begin
        if (ev[SW_DEC_EDGE])   state_nxt = ST_SLOWDN_CLS;
        else if (!to_close)    state_nxt = ST_NEG;
      end
      ST_SLOWDN_CLS: begin
        if (ev[SW_CLOSE_END])  state_nxt = ST_SHUT;
        else if (!to_close)    state_nxt = ST_SPEEDUP_OPN;
      end
      ST_SHUT:    if (!to_close) state_nxt = ST_SPEEDUP_OPN;
      ST_SPEEDUP_OPN: begin
        if (ev[SW_DEC_EDGE])   state_nxt = ST_NEG;
        else if (to_close)     state_nxt = ST_SLOWDN_CLS;
      end
      ST_NEG: begin
        if (ev[SW_ACC_EDGE])   state_nxt = ST_SLOWDN_OPN;
        else if (to_close)     state_nxt = ST_POS;
      end
      ST_SLOWDN_OPN: begin
        if (ev[SW_OPEN_END])   state_nxt = ST_OPEN;
        else if (to_close)     state_nxt = ST_SPEEDUP_CLS;
      end
      default:    state_nxt = state_r;
    endcase
  end

  // Speed command that goes with each transition. In homing the speed
  // follows the direction every tick until the end switch is seen.
  always_comb begin
    speed_nxt = speed_r;
    case (state_r)
      ST_HOMING: begin
        if (!to_close && ev[SW_OPEN_END])      speed_nxt = '0;
        else if (to_close && ev[SW_CLOSE_END]) speed_nxt = '0;
        else if (to_close)                     speed_nxt = home_p;
        else                                   speed_nxt = home_n;
      end
      ST_OPEN:    if (to_close) speed_nxt = creep_p;
      ST_SPEEDUP_CLS: begin
        if (ev[SW_ACC_EDGE])   speed_nxt = cruise_p;
        else if (!to_close)    speed_nxt = creep_n;
      end
      ST_POS: begin
        if (ev[SW_DEC_EDGE])   speed_nxt = creep_p;
        else if (!to_close)    speed_nxt = cruise_n;
      end
      ST_SLOWDN_CLS: begin
        if (ev[SW_CLOSE_END])  speed_nxt = '0;
        else if (!to_close)    speed_nxt = creep_n;
      end
      ST_SHUT:    if (!to_close) speed_nxt = creep_n;
      ST_SPEEDUP_OPN: begin
        if (ev[SW_DEC_EDGE])   speed_nxt = cruise_n;
        else if (to_close)     speed_nxt = creep_p;
      end
      ST_NEG: begin
        if (ev[SW_ACC_EDGE])   speed_nxt = creep_n;
        else if (to_close)     speed_nxt = cruise_p;
      end
      ST_SLOWDN_OPN: begin
        if (ev[SW_OPEN_END])   speed_nxt = '0;
        else if (to_close)     speed_nxt = creep_p;
      end
      default:    speed_nxt = speed_r;
    endcase
  end

  assign res_nxt.drive_speed    = speed_nxt;
  assign res_nxt.state_code     = state_nxt;
  assign res_nxt.switch_changed = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      speed_r <= '0;
      prev_r  <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      speed_r <= speed_nxt;
      prev_r  <= in_ch.switch_levels;
    end
  end

  // ---------------------------------------------------------- result buffer
  // The skid entry only fills when a request arrives while the output
  // register holds a result the receiver has not taken.
  assign out_free    = !out_v_r || out_ch.ready;
  assign in_ch.ready = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_r  <= skid_v_r || accept;
        skid_v_r <= 1'b0;
      end else if (accept) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : res_nxt;
    end
    if (!skid_v_r && !out_free) begin
      skid_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.drive_speed    = out_r.drive_speed;
  assign out_ch.state_code     = out_r.state_code;
  assign out_ch.switch_changed = out_r.switch_changed;

  // ------------------------------------------------------------- assertions
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid while output register empty");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_v_r)
    else $error("accepted request produced no result");

  a_stopped_at_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OPEN || state_r == ST_SHUT) |-> speed_r == '0)
    else $error("nonzero speed at an end position");

  a_pos_travel_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPEEDUP_CLS || state_r == ST_POS || state_r == ST_SLOWDN_CLS)
      |-> !speed_r[DRIVE_W-1])
    else $error("negative speed while traveling toward closed");

  a_no_stray_state: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(state_r))
    else $error("travel state changed without a request");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for door_drive_speed_fsm_top: bursty request traffic, a stalling
// receiver and a tick-accurate travel/speed predictor. Depends on ddsf_pkg and the three
// channel interfaces (ddsf_in_if, ddsf_out_if, ddsf_cfg_if).

import ddsf_pkg::*;

// Tracks the travel state, held speed and switch history of the door drive and keeps the
// results it owes, one per tick, in arrival order.
class door_speed_checker;
  logic [SPEED_W-1:0]        max_speed;
  logic [SPEED_W-1:0]        min_speed;
  travel_t                   travel;
  logic signed [DRIVE_W-1:0] held_speed;
  logic [SW_N-1:0]           prev_levels;
  result_t                   results_due[$];
  int                        mismatches;

  function new();
    max_speed   = 15'd1000;
    min_speed   = 15'd100;
    travel      = ST_INIT;
    held_speed  = '0;
    prev_levels = '0;
    mismatches  = 0;
  endfunction

  function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [SPEED_W-1:0] data);
    if (idx == CFG_MAX_SPEED) begin
      max_speed = data;
    end else if (idx == CFG_MIN_SPEED) begin
      min_speed = data;
    end
  endfunction

  function void move_to(travel_t nxt, int speed);
    travel     = nxt;
    held_speed = 16'(speed);
  endfunction

  function void predict_tick(logic toward_close, logic [SW_N-1:0] levels);
    logic [SW_N-1:0] ev;
    int              home;
    int              cruise;
    int              creep;
    result_t         r;
    ev     = levels ^ prev_levels;
    home   = int'(max_speed) / 5;
    cruise = int'(max_speed) / 2;
    creep  = int'(min_speed);
    case (travel)
      ST_INIT: begin
        travel = ST_HOMING;
      end
      ST_HOMING: begin
        held_speed = toward_close ? 16'(home) : 16'(-home);
        if (!toward_close && ev[SW_OPEN_END]) begin
          move_to(ST_OPEN, 0);
        end else if (toward_close && ev[SW_CLOSE_END]) begin
          move_to(ST_SHUT, 0);
        end
      end
      ST_OPEN: begin
        if (toward_close) move_to(ST_SPEEDUP_CLS, creep);
      end
      ST_SPEEDUP_CLS: begin
        if (ev[SW_ACC_EDGE]) move_to(ST_POS, cruise);
        else if (!toward_close) move_to(ST_SLOWDN_OPN, -creep);
      end
      ST_POS: begin
        if (ev[SW_DEC_EDGE]) move_to(ST_SLOWDN_CLS, creep);
        else if (!toward_close) move_to(ST_NEG, -cruise);
      end
      ST_SLOWDN_CLS: begin
        if (ev[SW_CLOSE_END]) move_to(ST_SHUT, 0);
        else if (!toward_close) move_to(ST_SPEEDUP_OPN, -creep);
      end
      ST_SHUT: begin
        if (!toward_close) move_to(ST_SPEEDUP_OPN, -creep);
      end
      ST_SPEEDUP_OPN: begin
        if (ev[SW_DEC_EDGE]) move_to(ST_NEG, -cruise);
        else if (toward_close) move_to(ST_SLOWDN_CLS, creep);
      end
      ST_NEG: begin
        if (ev[SW_ACC_EDGE]) move_to(ST_SLOWDN_OPN, -creep);
        else if (toward_close) move_to(ST_POS, cruise);
      end
      ST_SLOWDN_OPN: begin
        if (ev[SW_OPEN_END]) move_to(ST_OPEN, 0);
        else if (toward_close) move_to(ST_SPEEDUP_CLS, creep);
      end
      default: begin
      end
    endcase
    prev_levels      = levels;
    r.drive_speed    = held_speed;
    r.state_code     = travel;
    r.switch_changed = ev;
    results_due.push_back(r);
  endfunction

  task flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_tick_result(result_t got);
    result_t want;
    if (results_due.size() == 0) begin
      flag_mismatch("result arrived with no request outstanding");
    end else begin
      want = results_due.pop_front();
      if (got.drive_speed !== want.drive_speed)
        flag_mismatch($sformatf("drive_speed got %0d want %0d",
                                got.drive_speed, want.drive_speed));
      if (got.state_code !== want.state_code)
        flag_mismatch($sformatf("state_code got %0d want %0d",
                                got.state_code, want.state_code));
      if (got.switch_changed !== want.switch_changed)
        flag_mismatch($sformatf("switch_changed got %b want %b",
                                got.switch_changed, want.switch_changed));
    end
  endtask
endclass

module tb_top;

  // Register indexes the block has no register behind; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // Cycles with no handshake on any channel before the run is declared hung. Legal quiet
  // stretches come from receiver holds and sender gaps.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 6;
  localparam int TICKS_PER_PHASE = 215;

  // Directed walk, packed as {dir_close, switch_levels}. It starts with the init tick,
  // tries the wrong end switch in both directions while homing, homes at the open end,
  // then visits every zone in both directions, reverses in every moving state, and lands
  // a switch event and a reversal on the same tick to check that the event wins.
  localparam int DIRECTED_N = 22;
  localparam logic [4:0] DIRECTED_TICKS [DIRECTED_N] = '{
    5'b0_0000, 5'b1_0001, 5'b0_1001, 5'b0_1000, 5'b0_1000, 5'b1_1000,
    5'b1_1010, 5'b0_1010, 5'b1_1010, 5'b1_1110, 5'b0_1110, 5'b1_1110,
    5'b1_0110, 5'b1_0110, 5'b0_0110, 5'b1_0010, 5'b0_0000, 5'b1_0000,
    5'b0_0000, 5'b0_0001, 5'b1_1111, 5'b1_1101
  };

  typedef enum logic [1:0] {RX_FLOW, RX_HOLD, RX_JITTER} rx_mode_t;

  logic clk;
  logic rst_n;

  ddsf_in_if  in_ch();
  ddsf_out_if out_ch();
  ddsf_cfg_if cfg_ch();

  door_drive_speed_fsm_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  door_speed_checker sb;

  int       quiet_cycles;
  int       burst_left;
  logic     cur_dir;
  rx_mode_t rx_mode;
  int       rx_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: ready follows segments of random length, each either flowing freely,
  // holding off completely, or flipping at random every cycle. Long holds fill both
  // result entries in the block and push back on the request side.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(1, 32);
    end
    rx_left--;
    case (rx_mode)
      RX_FLOW:   out_ch.ready = 1'b1;
      RX_HOLD:   out_ch.ready = 1'b0;
      default:   out_ch.ready = 1'($urandom_range(0, 1));
    endcase
  end

  // Monitor on the rising edge. All channel signals are read before the block's own
  // registers update, so the order of processes within the step does not matter. A result
  // is checked before a request accepted on the same edge is predicted, since that result
  // always belongs to an older request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.apply_register(cfg_ch.idx, cfg_ch.data);
      if (out_ch.valid && out_ch.ready)
        sb.check_tick_result('{drive_speed: out_ch.drive_speed,
                               state_code: out_ch.state_code,
                               switch_changed: out_ch.switch_changed});
      if (in_ch.valid && in_ch.ready)
        sb.predict_tick(in_ch.dir_close, in_ch.switch_levels);
      if ((cfg_ch.valid && cfg_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (in_ch.valid && in_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("door_drive_speed_fsm_top verification failed");
        $finish;
      end
    end
  end

  // Presents one request from a falling edge and returns at the falling edge after it was
  // accepted, with valid still high so that back-to-back requests follow without a gap.
  task send_request(input logic toward_close, input logic [3:0] levels);
    in_ch.valid         = 1'b1;
    in_ch.dir_close     = toward_close;
    in_ch.switch_levels = levels;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Burst pacing of the sender: after a burst of random length, valid drops for a
  // random gap. About a quarter of the bursts run straight into the next one.
  task pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SPEED_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.idx   = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Stops the sender and waits until every owed result has come back, plus a short
  // margin, so that register writes land on an idle block.
  task drain_results();
    in_ch.valid = 1'b0;
    while (sb.results_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Chooses the next tick from the predicted travel state. Most ticks toggle the switch
  // that ends the current zone, so the door keeps moving through the full cycle. The
  // direction is sticky while moving and changes often at the ends so the door leaves
  // them. The rest are stray single toggles, arbitrary levels and ticks with no change.
  task pick_request(output logic toward_close, output logic [3:0] levels);
    int roll;
    int flip_pct;
    int target;
    int stray;
    flip_pct = (sb.travel == ST_OPEN || sb.travel == ST_SHUT) ? 35 : 4;
    if ($urandom_range(0, 99) < flip_pct) cur_dir = ~cur_dir;
    case (sb.travel)
      ST_HOMING:                  target = cur_dir ? SW_CLOSE_END : SW_OPEN_END;
      ST_SPEEDUP_CLS, ST_NEG:     target = SW_ACC_EDGE;
      ST_POS, ST_SPEEDUP_OPN:     target = SW_DEC_EDGE;
      ST_SLOWDN_CLS:              target = SW_CLOSE_END;
      ST_SLOWDN_OPN:              target = SW_OPEN_END;
      default:                    target = $urandom_range(0, SW_N - 1);
    endcase
    levels = sb.prev_levels;
    roll   = $urandom_range(0, 99);
    if (roll < 60) begin
      levels[target] = ~levels[target];
    end else if (roll < 72) begin
      stray = $urandom_range(0, SW_N - 1);
      levels[stray] = ~levels[stray];
    end else if (roll < 84) begin
      levels = 4'($urandom_range(0, 15));
    end
    toward_close = cur_dir;
  endtask

  initial begin
    logic       d;
    logic [3:0] lv;
    sb                  = new();
    quiet_cycles        = 0;
    burst_left          = 0;
    cur_dir             = 1'b0;
    rx_mode             = RX_FLOW;
    rx_left             = 0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.dir_close     = 1'b0;
    in_ch.switch_levels = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.idx          = CFG_MAX_SPEED;
    cfg_ch.data         = '0;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed walk under the reset speeds.
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_request(DIRECTED_TICKS[i][4], DIRECTED_TICKS[i][3:0]);
      pace_sender();
    end
    cur_dir = DIRECTED_TICKS[DIRECTED_N-1][4];

    // Random phases, each under its own speed setting. The held speed is not rescaled by
    // a write, so every phase also checks that the old speed survives until the next
    // zone change.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          write_register(CFG_MAX_SPEED, 15'h7FFF);
          write_register(CFG_MIN_SPEED, 15'h7FFF);
        end
        1: begin
          write_register(CFG_MAX_SPEED, 15'd0);
          write_register(CFG_MIN_SPEED, 15'd0);
        end
        2: begin
          // Home speed truncates to zero and cruise to two.
          write_register(CFG_MAX_SPEED, 15'd4);
          write_register(CFG_MIN_SPEED, 15'd1);
        end
        3: begin
          write_register(CFG_MAX_SPEED, 15'($urandom_range(0, 32767)));
          write_register(CFG_MIN_SPEED, 15'($urandom_range(0, 32767)));
          // Writes past the last register must leave both speeds alone.
          write_register(CFG_SPARE_2, 15'($urandom_range(0, 32767)));
          write_register(CFG_SPARE_3, 15'($urandom_range(0, 32767)));
        end
        4: begin
          write_register(CFG_MAX_SPEED, 15'h7FFF);
          write_register(CFG_MIN_SPEED, 15'd0);
        end
        default: begin
          write_register(CFG_MIN_SPEED, 15'($urandom_range(0, 2000)));
          write_register(CFG_MAX_SPEED, 15'($urandom_range(2000, 32767)));
        end
      endcase
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        pick_request(d, lv);
        send_request(d, lv);
        pace_sender();
      end
    end

    drain_results();
    if (sb.mismatches == 0) begin
      $display("door_drive_speed_fsm_top verification clean");
    end else begin
      $display("door_drive_speed_fsm_top verification failed");
    end
    $finish;
  end

endmodule
